### rtl/aesrt_pkg.sv
package aesrt_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] cmd_t;
    typedef logic [127:0] blk_t;

    localparam cmd_t CMD_ADD_KEY   = 3'd0;
    localparam cmd_t CMD_SUB       = 3'd1;
    localparam cmd_t CMD_INV_SUB   = 3'd2;
    localparam cmd_t CMD_SHIFT     = 3'd3;
    localparam cmd_t CMD_INV_SHIFT = 3'd4;
    localparam cmd_t CMD_MIX       = 3'd5;
    localparam cmd_t CMD_INV_MIX   = 3'd6;

    localparam byte_t POLY_LOW = 8'h1b;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic byte_t xtime(byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW : 8'h00);
    endfunction

    // byte k of a block sits in bits 127-8k downto 120-8k
    function automatic byte_t get_byte(blk_t b, int k);
        return b[127 - 8*k -: 8];
    endfunction

endpackage

### rtl/aesrt_bytes.sv
module aesrt_bytes (
    input  aesrt_pkg::cmd_t command,
    input  aesrt_pkg::blk_t state,
    input  aesrt_pkg::blk_t key,
    output aesrt_pkg::blk_t result
);
    import aesrt_pkg::*;

    // bytewise operations and row permutations
    always_comb
    begin
        result = state;
        for (int k = 0; k < 16; k++)
        begin
            case (command)
                CMD_ADD_KEY:   result[127 - 8*k -: 8] = get_byte(state, k) ^ get_byte(key, k);
                CMD_SUB:       result[127 - 8*k -: 8] = SBOX[get_byte(state, k)];
                CMD_INV_SUB:   result[127 - 8*k -: 8] = INV_SBOX[get_byte(state, k)];
                CMD_SHIFT:     result[127 - 8*k -: 8] =
                                   get_byte(state, (((k/4) + (k%4)) % 4) * 4 + (k%4));
                CMD_INV_SHIFT: result[127 - 8*k -: 8] =
                                   get_byte(state, (((k/4) + 4 - (k%4)) % 4) * 4 + (k%4));
                default:       result[127 - 8*k -: 8] = get_byte(state, k);
            endcase
        end
    end
endmodule

### rtl/aesrt_mix.sv
module aesrt_mix (
    input  logic            inverse,
    input  aesrt_pkg::blk_t state,
    output aesrt_pkg::blk_t result
);
    import aesrt_pkg::*;

    // column mixing, one independent column per lane
    always_comb
    begin
        byte_t a0, a1, a2, a3, a4, a8;
        byte_t m;
        result = state;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                m = 8'h00;
                for (int j = 0; j < 4; j++)
                begin
                    a1 = get_byte(state, c*4 + ((r + j) % 4));
                    a2 = xtime(a1);
                    a4 = xtime(a2);
                    a8 = xtime(a4);
                    a0 = 8'h00;
                    if (!inverse)
                    begin
                        case (j)
                            0:       a0 = a2;
                            1:       a0 = a2 ^ a1;
                            default: a0 = a1;
                        endcase
                    end
                    else
                    begin
                        case (j)
                            0:       a0 = a8 ^ a4 ^ a2;
                            1:       a0 = a8 ^ a2 ^ a1;
                            2:       a0 = a8 ^ a4 ^ a1;
                            default: a0 = a8 ^ a1;
                        endcase
                    end
                    m = m ^ a0;
                end
                result[127 - 8*(c*4 + r) -: 8] = m;
            end
        end
    end
endmodule

### rtl/aes_round_transforms.sv
// The result strobe follows the start request through the input and result registers.
// Throughput: one request per cycle; busy is held low.
// Reset: rst_n asynchronous, active low; clears the valid pipeline only.
// The receiver cannot stall: each result is shown for exactly one cycle.
module aes_round_transforms (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  aesrt_pkg::cmd_t  command,
    input  logic [63:0]      state_high,
    input  logic [63:0]      state_low,
    input  logic [63:0]      key_high,
    input  logic [63:0]      key_low,
    output logic             done,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low
);
    import aesrt_pkg::*;

    logic  in_valid_reg, out_valid_reg;
    cmd_t  cmd_reg;
    blk_t  state_reg, key_reg, res_reg;
    blk_t  byte_res, mix_res, res_next;

    assign busy = 1'b0;

    // hold control valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    // capture request payload and register the result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg   <= command;
            state_reg <= {state_high, state_low};
            key_reg   <= {key_high, key_low};
        end
        if (in_valid_reg)
            res_reg <= res_next;
    end

    aesrt_bytes u_bytes (.command(cmd_reg), .state(state_reg), .key(key_reg), .result(byte_res));
    aesrt_mix   u_mix   (.inverse(cmd_reg == CMD_INV_MIX), .state(state_reg), .result(mix_res));

    // select the transform result
    assign res_next = (cmd_reg == CMD_MIX || cmd_reg == CMD_INV_MIX) ? mix_res : byte_res;

    assign done        = out_valid_reg;
    assign result_high = res_reg[127:64];
    assign result_low  = res_reg[63:0];
endmodule

### rtl/aesrt_checker.sv
module aesrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done) else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2)) else $error("spurious result");
endmodule

bind aes_round_transforms aesrt_checker u_chk (.clk(clk), .rst_n(rst_n), .start(start),
    .busy(busy), .done(done));

### bench/aes_round_checker.sv
module aes_round_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  aesrt_pkg::cmd_t  command,
    input  logic [63:0]      state_high,
    input  logic [63:0]      state_low,
    input  logic [63:0]      key_high,
    input  logic [63:0]      key_low,
    input  logic             done,
    input  logic [63:0]      result_high,
    input  logic [63:0]      result_low,
    output int               fail_count,
    output int               pending_count
);
    import aesrt_pkg::*;

    logic [127:0] expected_blocks[$];

    // multiply in GF(2^8) by shift and add
    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // inverse as a^254; zero maps to zero
    function automatic logic [7:0] ginv(logic [7:0] a);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 0)
                r = gmul(r, p);
            p = gmul(p, p);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [127:0] transform_block(cmd_t cmd, logic [127:0] st_in,
                                                    logic [127:0] key_in);
        logic [7:0] st[16];
        logic [7:0] ky[16];
        logic [7:0] res[16];
        logic [7:0] b;
        logic [127:0] packed_res;
        int c;
        int r;
        for (int k = 0; k < 16; k++)
        begin
            st[k] = st_in[127 - 8*k -: 8];
            ky[k] = key_in[127 - 8*k -: 8];
            res[k] = st[k];
        end
        case (cmd)
            CMD_ADD_KEY:
                for (int k = 0; k < 16; k++)
                    res[k] = st[k] ^ ky[k];
            CMD_SUB:
                for (int k = 0; k < 16; k++)
                begin
                    b = ginv(st[k]);
                    res[k] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
                end
            CMD_INV_SUB:
                for (int k = 0; k < 16; k++)
                    res[k] = ginv(rol8(st[k], 1) ^ rol8(st[k], 3) ^ rol8(st[k], 6) ^ 8'h05);
            CMD_SHIFT:
                for (c = 0; c < 4; c++)
                    for (r = 0; r < 4; r++)
                        res[c*4 + r] = st[((c + r) % 4)*4 + r];
            CMD_INV_SHIFT:
                for (c = 0; c < 4; c++)
                    for (r = 0; r < 4; r++)
                        res[((c + r) % 4)*4 + r] = st[c*4 + r];
            CMD_MIX:
                for (c = 0; c < 4; c++)
                    for (r = 0; r < 4; r++)
                        res[c*4 + r] = gmul(st[c*4 + r], 8'h02)
                            ^ gmul(st[c*4 + (r + 1) % 4], 8'h03)
                            ^ st[c*4 + (r + 2) % 4] ^ st[c*4 + (r + 3) % 4];
            CMD_INV_MIX:
                for (c = 0; c < 4; c++)
                    for (r = 0; r < 4; r++)
                        res[c*4 + r] = gmul(st[c*4 + r], 8'h0e)
                            ^ gmul(st[c*4 + (r + 1) % 4], 8'h0b)
                            ^ gmul(st[c*4 + (r + 2) % 4], 8'h0d)
                            ^ gmul(st[c*4 + (r + 3) % 4], 8'h09);
            default: ;
        endcase
        for (int k = 0; k < 16; k++)
            packed_res[127 - 8*k -: 8] = res[k];
        return packed_res;
    endfunction

    initial fail_count = 0;
    assign pending_count = expected_blocks.size();

    // predict on each accepted request, compare each strobed result
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (result_high !== want[127:64])
                begin
                    $error("result_high expected %h actual %h", want[127:64], result_high);
                    fail_count++;
                end
                if (result_low !== want[63:0])
                begin
                    $error("result_low expected %h actual %h", want[63:0], result_low);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && !busy)
            expected_blocks.insert(expected_blocks.size(),
                                   transform_block(command, {state_high, state_low},
                                                   {key_high, key_low}));
    end
endmodule

### bench/aes_round_transforms_test.sv
module aes_round_transforms_test;
    import aesrt_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    cmd_t            command;
    logic [63:0]     state_high;
    logic [63:0]     state_low;
    logic [63:0]     key_high;
    logic [63:0]     key_low;
    logic            done;
    logic [63:0]     result_high;
    logic [63:0]     result_low;
    int              fail_count;
    int              pending_count;

    aes_round_transforms uut (.*);

    aes_round_checker checker_inst (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // biased byte pattern: edges often, random otherwise
    function automatic logic [63:0] pattern64();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8080808080808080;
            3: return 64'h0101010101010101;
            default: return rand64();
        endcase
    endfunction

    // present one request and hold it until accepted
    task automatic send_request(cmd_t cmd, logic [63:0] sh, logic [63:0] sl,
                                logic [63:0] kh, logic [63:0] kl);
        start <= 1'b1;
        command <= cmd;
        state_high <= sh;
        state_low <= sl;
        key_high <= kh;
        key_low <= kl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        if ($urandom_range(0, 2) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_ADD_KEY;
        state_high = '0;
        state_low = '0;
        key_high = '0;
        key_low = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every command on extreme states, unused command, stray key
        for (int c = 0; c < 8; c++)
        begin
            send_request(cmd_t'(c), 64'h0, 64'h0, '1, '1);
            send_request(cmd_t'(c), '1, '1, 64'h0, 64'h0);
        end
        send_request(CMD_ADD_KEY, 64'h0011223344556677, 64'h8899aabbccddeeff,
                     64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_request(CMD_MIX, 64'hdb135345f20a225c, 64'h01010101c6c6c6c6, '1, 64'h0);
        send_request(CMD_INV_MIX, 64'h8e4da1bc9fdc589d, 64'h01010101c6c6c6c6, 64'h0, '1);
        send_request(CMD_SUB, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_request(CMD_INV_SUB, 64'h637c777bf26b6fc5, 64'h3001672bfed7ab76, '1, '1);

        // random requests with random gaps and back-to-back stretches
        for (int n = 0; n < 1350; n++)
        begin
            if (n % 200 >= 150)
                ;
            else
                idle_gap();
            send_request(cmd_t'($urandom_range(0, 7)), pattern64(), pattern64(),
                         pattern64(), pattern64());
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 1000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (5) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // guard against a hung run
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
